### src/tmt_pkg.sv
// Shared constants and types of the tiled matrix transpose (corner turn).
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package tmt_pkg;

    // Tile geometry and element width
    localparam int TILE       = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed port widths
    localparam int CFG_W      = 16;
    localparam int VALUE_W    = 32;
    localparam int ADDR_OUT_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Derived geometry
    localparam int AREA      = TILE * TILE;
    localparam int TILE_W    = $clog2(TILE);
    localparam int POS_W     = $clog2(AREA);
    localparam int MEM_DEPTH = 2 * AREA;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int MAX_TILES = ((1 << CFG_W) - 1 + TILE - 1) / TILE;
    localparam int TIDX_W    = $clog2(MAX_TILES);
    localparam int CO_W      = TIDX_W + TILE_W;
    localparam int CMP_W     = ((CO_W > CFG_W) ? CO_W : CFG_W) + 1;
    localparam int ROWX_W    = TIDX_W + TILE_W + 1;
    localparam int STORE_W   = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    // Result queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS   = CFG_IDX_W'(0),
        CFG_COLS   = CFG_IDX_W'(1),
        CFG_STRIDE = CFG_IDX_W'(2)
    } cfg_index_t;

    // One result on its way from the front to the back
    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [ADDR_OUT_W-1:0] product;
        logic [CO_W-1:0]       ocol;
        logic                  last;
    } q_entry_t;

endpackage

### src/tmt_front.sv
// Front part of the corner turn: accepts requests, writes the ping-pong tile
// store, reads the full bank in transposed order and forms partial results.
// Depends on tmt_pkg.
`timescale 1ns / 1ps
module tmt_front
    import tmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_W-1:0]    elem_value,
    input  logic                  drain,
    input  logic [CFG_W-1:0]      rows,
    input  logic [CFG_W-1:0]      cols,
    input  logic [CFG_W-1:0]      out_stride,
    input  logic [QCNT_W-1:0]     q_count,
    output logic                  push,
    output q_entry_t              push_entry
);

    logic [STORE_W-1:0] mem [MEM_DEPTH];

    logic               write_bank_reg, write_bank_next;
    logic [POS_W-1:0]   in_pos_reg, in_pos_next;
    logic [TIDX_W-1:0]  in_tile_row_reg, in_tile_row_next;
    logic [TIDX_W-1:0]  in_tile_col_reg, in_tile_col_next;
    logic               rd_full_reg, rd_full_next;
    logic [TIDX_W-1:0]  rd_tile_row_reg, rd_tile_row_next;
    logic [TIDX_W-1:0]  rd_tile_col_reg, rd_tile_col_next;
    logic               rd_final_reg, rd_final_next;
    logic [TILE_W-1:0]  rd_r_reg, rd_r_next;
    logic [TILE_W-1:0]  rd_c_reg, rd_c_next;

    logic               s1_valid_reg, s1_valid_next;
    logic [CO_W-1:0]    s1_orow_reg;
    logic [CO_W-1:0]    s1_ocol_reg;
    logic               s1_last_reg;
    logic [STORE_W-1:0] rdata_reg;

    logic               accept;
    logic               rd_step;
    logic               rd_last_pos;
    logic [CO_W-1:0]    orow;
    logic [CO_W-1:0]    ocol;
    logic               in_bounds;
    logic               is_last;
    logic [POS_W-1:0]   rd_idx;
    logic [MEM_AW-1:0]  raddr;
    logic [MEM_AW-1:0]  waddr;
    logic               wr_en;
    logic               tile_done;
    logic               row_end;
    logic               col_end;

    // Room is counted for the result already in the read stage, so a push
    // always finds a free queue slot.
    assign in_stall = ({1'b0, q_count} + (QCNT_W + 1)'(s1_valid_reg))
                      >= (QCNT_W + 1)'(QDEPTH);
    assign accept   = in_valid & ~in_stall;

    // Read side: position (r, c) of the held tile, column index moving fastest
    assign rd_step     = accept & rd_full_reg;
    assign rd_last_pos = (rd_r_reg == TILE_W'(TILE - 1)) && (rd_c_reg == TILE_W'(TILE - 1));
    assign orow = CO_W'(rd_tile_col_reg) * CO_W'(TILE) + CO_W'(rd_r_reg);
    assign ocol = CO_W'(rd_tile_row_reg) * CO_W'(TILE) + CO_W'(rd_c_reg);
    assign in_bounds = (CMP_W'(orow) < CMP_W'(cols)) && (CMP_W'(ocol) < CMP_W'(rows));
    assign is_last   = rd_final_reg
                       && ((CMP_W'(orow) + CMP_W'(1)) == CMP_W'(cols))
                       && ((CMP_W'(ocol) + CMP_W'(1)) == CMP_W'(rows));
    assign rd_idx = POS_W'(rd_c_reg) * POS_W'(TILE) + POS_W'(rd_r_reg);
    assign raddr  = write_bank_reg ? MEM_AW'(rd_idx) : MEM_AW'(AREA) + MEM_AW'(rd_idx);

    // Write side
    assign wr_en     = accept & ~drain;
    assign tile_done = wr_en && (in_pos_reg == POS_W'(AREA - 1));
    assign waddr     = write_bank_reg ? MEM_AW'(AREA) + MEM_AW'(in_pos_reg)
                                      : MEM_AW'(in_pos_reg);
    // Last tile row or column when the next tile edge reaches the extent.
    assign row_end = (ROWX_W'(in_tile_row_reg) + ROWX_W'(1)) * ROWX_W'(TILE)
                     >= ROWX_W'(rows);
    assign col_end = (ROWX_W'(in_tile_col_reg) + ROWX_W'(1)) * ROWX_W'(TILE)
                     >= ROWX_W'(cols);

    always_comb
    begin
        write_bank_next  = write_bank_reg;
        in_pos_next      = in_pos_reg;
        in_tile_row_next = in_tile_row_reg;
        in_tile_col_next = in_tile_col_reg;
        rd_full_next     = rd_full_reg;
        rd_tile_row_next = rd_tile_row_reg;
        rd_tile_col_next = rd_tile_col_reg;
        rd_final_next    = rd_final_reg;
        rd_r_next        = rd_r_reg;
        rd_c_next        = rd_c_reg;

        if (rd_step)
        begin
            if (rd_last_pos)
            begin
                rd_full_next = 1'b0;
                rd_r_next    = '0;
                rd_c_next    = '0;
            end
            else if (rd_c_reg == TILE_W'(TILE - 1))
            begin
                rd_c_next = '0;
                rd_r_next = rd_r_reg + TILE_W'(1);
            end
            else
            begin
                rd_c_next = rd_c_reg + TILE_W'(1);
            end
        end

        // A completed tile hands its bank to the read side.
        if (wr_en)
        begin
            if (tile_done)
            begin
                in_pos_next      = '0;
                rd_full_next     = 1'b1;
                rd_r_next        = '0;
                rd_c_next        = '0;
                rd_tile_row_next = in_tile_row_reg;
                rd_tile_col_next = in_tile_col_reg;
                rd_final_next    = row_end & col_end;
                write_bank_next  = ~write_bank_reg;
                if (col_end)
                begin
                    in_tile_col_next = '0;
                    in_tile_row_next = row_end ? '0 : in_tile_row_reg + TIDX_W'(1);
                end
                else
                begin
                    in_tile_col_next = in_tile_col_reg + TIDX_W'(1);
                end
            end
            else
            begin
                in_pos_next = in_pos_reg + POS_W'(1);
            end
        end
    end

    assign s1_valid_next = rd_step & in_bounds;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_bank_reg  <= 1'b0;
            in_pos_reg      <= '0;
            in_tile_row_reg <= '0;
            in_tile_col_reg <= '0;
            rd_full_reg     <= 1'b0;
            rd_tile_row_reg <= '0;
            rd_tile_col_reg <= '0;
            rd_final_reg    <= 1'b0;
            rd_r_reg        <= '0;
            rd_c_reg        <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            write_bank_reg  <= write_bank_next;
            in_pos_reg      <= in_pos_next;
            in_tile_row_reg <= in_tile_row_next;
            in_tile_col_reg <= in_tile_col_next;
            rd_full_reg     <= rd_full_next;
            rd_tile_row_reg <= rd_tile_row_next;
            rd_tile_col_reg <= rd_tile_col_next;
            rd_final_reg    <= rd_final_next;
            rd_r_reg        <= rd_r_next;
            rd_c_reg        <= rd_c_next;
            s1_valid_reg    <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_step)
        begin
            s1_orow_reg <= orow;
            s1_ocol_reg <= ocol;
            s1_last_reg <= is_last;
        end
    end

    // Tile store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= STORE_W'(elem_value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_step)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign push               = s1_valid_reg;
    assign push_entry.value   = VALUE_W'(rdata_reg);
    assign push_entry.product = ADDR_OUT_W'(s1_orow_reg) * ADDR_OUT_W'(out_stride);
    assign push_entry.ocol    = s1_ocol_reg;
    assign push_entry.last    = s1_last_reg;

    // The write side may only swap banks once the held tile is fully read.
    a_swap_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (tile_done && rd_full_reg) |-> rd_last_pos)
        else $error("tile completed while the read bank is still being read");

    a_read_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !rd_full_reg |-> ((rd_r_reg == '0) && (rd_c_reg == '0)))
        else $error("read position away from the tile start while no tile is held");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_count < QCNT_W'(QDEPTH)))
        else $error("result pushed into a full queue");

endmodule

### src/tmt_queue.sv
// Short result queue between the front and back parts of the corner turn.
// Depends on tmt_pkg.
`timescale 1ns / 1ps
module tmt_queue
    import tmt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  q_entry_t          push_entry,
    input  logic              pop,
    output q_entry_t          head,
    output logic [QCNT_W-1:0] count
);

    q_entry_t            entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head  = entries_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

### src/tmt_back.sv
// Back part of the corner turn: takes results from the queue, finishes the
// output address and holds the result until the receiver takes it.
// Depends on tmt_pkg.
`timescale 1ns / 1ps
module tmt_back
    import tmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  q_entry_t              head,
    input  logic [QCNT_W-1:0]     q_count,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_W-1:0]    out_value,
    output logic [ADDR_OUT_W-1:0] out_address,
    output logic                  last_elem
);

    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]    out_value_reg;
    logic [ADDR_OUT_W-1:0] out_address_reg;
    logic                  last_elem_reg;

    // The output register refills whenever the queue is not empty and the register is empty or being taken.
    assign pop = (q_count != '0) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_value_reg   <= head.value;
            out_address_reg <= head.product + ADDR_OUT_W'(head.ocol);
            last_elem_reg   <= head.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_address = out_address_reg;
    assign last_elem   = last_elem_reg;

endmodule

### src/tiled_matrix_transpose_top.sv
// Top level of the tiled matrix transpose (corner turn).
// Holds the configuration registers and connects tmt_front, tmt_queue and
// tmt_back; depends on tmt_pkg.
//
// Usage: the sender streams requests on in_valid / in_stall, one element per
// request, tiles in raster order and row-major inside each tile, padding
// positions of edge tiles included. A request with drain set writes nothing
// and only moves the read side on. Every request advances the transposed
// read of the last full tile by one position; in-bounds positions come out
// on out_valid / out_stall with out_value, out_address and last_elem.
// Throughput: one request per cycle while in_stall is low, set by the single
// write port and the single registered read port of the two-bank tile store.
// A result passes from the registered read of the store through the queue
// into the output register, and elements of a tile are read during the next
// tile's worth of requests (one TILE*TILE tile of delay, or drain requests).
// When the receiver stalls, the output register holds its result, the
// four-entry queue fills, and in_stall rises once it has no room left.
// Reset clears all counters and control, sets rows, cols and out_stride to
// 16, leaves the tile store unknown and holds no tile. Configuration must
// be written via cfg_we/cfg_index/cfg_data only while idle; not enforced.
`timescale 1ns / 1ps
module tiled_matrix_transpose_top
    import tmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_W-1:0]    elem_value,
    input  logic                  drain,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_W-1:0]    out_value,
    output logic [ADDR_OUT_W-1:0] out_address,
    output logic                  last_elem,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic [CFG_W-1:0]  rows_reg, rows_next;
    logic [CFG_W-1:0]  cols_reg, cols_next;
    logic [CFG_W-1:0]  stride_reg, stride_next;

    logic              push;
    logic              pop;
    q_entry_t          push_entry;
    q_entry_t          head;
    logic [QCNT_W-1:0] q_count;

    always_comb
    begin
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        stride_next = stride_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS:   rows_next   = cfg_data;
                CFG_COLS:   cols_next   = cfg_data;
                CFG_STRIDE: stride_next = cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= CFG_RESET;
            cols_reg   <= CFG_RESET;
            stride_reg <= CFG_RESET;
        end
        else
        begin
            rows_reg   <= rows_next;
            cols_reg   <= cols_next;
            stride_reg <= stride_next;
        end
    end

    tmt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .elem_value (elem_value),
        .drain      (drain),
        .rows       (rows_reg),
        .cols       (cols_reg),
        .out_stride (stride_reg),
        .q_count    (q_count),
        .push       (push),
        .push_entry (push_entry)
    );

    tmt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .count      (q_count)
    );

    tmt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_count     (q_count),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_value   (out_value),
        .out_address (out_address),
        .last_elem   (last_elem)
    );

endmodule
